>>> design/hlsc_pkg.sv
// Shared types and constants of the gray-to-HLS colorizer.
// Used by hlsc_calc and by the top level gray_to_hls_colorize; depends on nothing.
package hlsc_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_HUE = 1'b0,
    REG_SAT = 1'b1
  } cfg_reg_t;

  localparam int LEVEL_W  = 8;
  localparam int HUE_W    = 9;
  localparam int SAT_W    = 7;
  localparam int TABLE_AW = LEVEL_W;

  // Red sits in the lowest byte so that the packed pixel is the output tdata.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Status and table write port from the colour calculator to the top level.
  typedef struct packed {
    logic                busy;
    logic                wr_valid;
    logic [TABLE_AW-1:0] wr_addr;
    rgb_t                wr_px;
  } calc_st_t;

endpackage

>>> design/hlsc_calc.sv
// Four-stage pipeline that turns one gray level into its colorized RGB pixel.
// Depends on hlsc_pkg; its results fill the lookup table of the top level.
module hlsc_calc
  import hlsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               flush,
  input  logic               in_valid,
  input  logic [LEVEL_W-1:0] in_level,
  input  logic [HUE_W-1:0]   hue,
  input  logic [SAT_W-1:0]   sat,
  output calc_st_t           st
);

  localparam int          NCH       = 3;
  localparam int          DIV_SHIFT = 34;
  localparam int          DIVISOR   = 6000;
  localparam longint unsigned DIV_MAGIC =
    ((64'd1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic signed [10:0] HUE_OFS [NCH] = '{11'sd120, 11'sd0, -11'sd120};

  // Hue weight of one channel: wraps the offset hue once and maps it onto the
  // ramp, so that a channel is (60*M1 + (M2-M1)*weight) / 6000. The flat top
  // segment has weight 60 and the flat bottom segment weight 0.
  function automatic logic [5:0] hue_weight(input logic signed [10:0] h);
    logic signed [10:0] w;
    logic [8:0]         u;
    w = h;
    if (w > 11'sd360) w = w - 11'sd360;
    if (w < 11'sd0) w = w + 11'sd360;
    u = w[8:0];
    if (u < 9'd60) return u[5:0];
    else if (u < 9'd180) return 6'd60;
    else if (u < 9'd240) return 6'(9'd240 - u);
    else return 6'd0;
  endfunction

  // Stage 1: clamp, lightness times saturation, hue weights.
  logic               s1_valid;
  logic [LEVEL_W-1:0] s1_level;
  logic [SAT_W-1:0]   s1_sat;
  logic [14:0]        s1_ls;
  logic [5:0]         s1_f [NCH];

  // Stage 2: levels M1 and M2 - M1.
  logic               s2_valid;
  logic [LEVEL_W-1:0] s2_level;
  logic [14:0]        s2_m1;
  logic [15:0]        s2_d;
  logic [5:0]         s2_f [NCH];

  // Stage 3: ramp numerators.
  logic               s3_valid;
  logic [LEVEL_W-1:0] s3_level;
  logic [20:0]        s3_num [NCH];

  // Stage 4: quotients, written to the table.
  logic               s4_valid;
  logic [LEVEL_W-1:0] s4_level;
  rgb_t               s4_px;

  logic [SAT_W-1:0] sat_cl;
  logic [14:0]      m1_c;
  logic [14:0]      m2_c;
  logic [15:0]      d_c;
  logic [7:0]       q_c [NCH];

  assign sat_cl = (sat > SAT_W'(100)) ? SAT_W'(100) : sat;

  always_comb begin
    logic [16:0] l100;
    logic [16:0] m2_n;
    l100 = 17'(s1_level) * 17'd100;
    if (s1_level <= 8'd127) begin
      m2_n = l100 + 17'(s1_ls);
    end else begin
      m2_n = l100 + 17'(s1_sat) * 17'd255 - 17'(s1_ls);
    end
    m2_c = m2_n[14:0];
    m1_c = 15'(17'(s1_level) * 17'd200 - m2_n);
    d_c  = 16'(m2_c) - 16'(m1_c);
  end

  always_comb begin
    logic [42:0] prod;
    for (int c = 0; c < NCH; c++) begin
      prod   = 43'(s3_num[c]) * 43'(DIV_MAGIC);
      q_c[c] = prod[DIV_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_level <= in_level;
    s1_sat   <= sat_cl;
    s1_ls    <= 15'(in_level) * 15'(sat_cl);
    for (int c = 0; c < NCH; c++) begin
      s1_f[c] <= hue_weight($signed({2'b00, hue}) + HUE_OFS[c]);
    end

    s2_level <= s1_level;
    s2_m1    <= m1_c;
    s2_d     <= d_c;
    s2_f     <= s1_f;

    s3_level <= s2_level;
    for (int c = 0; c < NCH; c++) begin
      s3_num[c] <= 21'(s2_m1) * 21'd60 + 21'(s2_d) * 21'(s2_f[c]);
    end

    s4_level    <= s3_level;
    s4_px.red   <= q_c[0];
    s4_px.green <= q_c[1];
    s4_px.blue  <= q_c[2];
  end

  assign st.busy     = s1_valid || s2_valid || s3_valid || s4_valid;
  assign st.wr_valid = s4_valid;
  assign st.wr_addr  = s4_level;
  assign st.wr_px    = s4_px;

endmodule

>>> design/gray_to_hls_colorize.sv
// Top level of the gray-to-HLS colorizer: lookup table, its rebuild sequencer
// and the output queue. Depends on hlsc_pkg and hlsc_calc.
//
// Usage: gray levels arrive on the s_axis stream, one per item; each gives one
// RGB pixel on the m_axis stream, in order. Hue and saturation are written on
// the cfg channel (index 0 hue in degrees, index 1 saturation in percent),
// which is always ready.
// Every pixel is looked up in a 256-entry table holding the colour of each
// gray level. After reset and after every configuration write the table is
// rebuilt by a four-stage colour pipeline, one entry per cycle; s_axis_tready
// stays low until the last entry is written, and a further write restarts the rebuild.
// Once the table is built the block takes one item per cycle while the receiver
// keeps up; a pixel passes the table read register and then the output queue
// before it appears on m_axis.
// When the receiver stalls, results wait in a three-entry output queue and
// input is refused once the queue and the read stage together hold three items.
// Reset clears the queue, sets hue and saturation to zero and starts a rebuild.
module gray_to_hls_colorize
  import hlsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] gray_level
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [HUE_W-1:0]    cfg_data
);

  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int QUEUE_DEPTH = 3;

  logic [HUE_W-1:0]  hue;
  logic [SAT_W-1:0]  sat;
  logic [TABLE_AW:0] fill_addr;
  logic              filling;
  logic              cfg_wr;
  logic              busy;
  calc_st_t          calc_st;

  rgb_t              table_mem [TABLE_DEPTH];
  rgb_t              table_q;
  logic              rd_en;
  logic              rd_valid;

  rgb_t              queue [QUEUE_DEPTH];
  logic [1:0]        q_wr_ptr;
  logic [1:0]        q_rd_ptr;
  logic [1:0]        q_count;
  logic              q_pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue <= '0;
      sat <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HUE: hue <= cfg_data;
        REG_SAT: sat <= cfg_data[SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Rebuild sequencer: the top bit of fill_addr marks the sweep as done.
  assign filling = !fill_addr[TABLE_AW];

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      fill_addr <= '0;
    end else if (filling) begin
      fill_addr <= fill_addr + 1'b1;
    end
  end

  hlsc_calc u_calc (
    .clk      (clk),
    .rst      (rst),
    .flush    (cfg_wr),
    .in_valid (filling),
    .in_level (fill_addr[TABLE_AW-1:0]),
    .hue      (hue),
    .sat      (sat),
    .st       (calc_st)
  );

  // The table is never read while it is being written, so no forwarding is needed.
  assign busy          = filling || calc_st.busy;
  assign s_axis_tready = !busy && ((3'(rd_valid) + 3'(q_count)) <= 3'(QUEUE_DEPTH - 1));
  assign rd_en         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (calc_st.wr_valid) begin
      table_mem[calc_st.wr_addr] <= calc_st.wr_px;
    end
    if (rd_en) begin
      table_q <= table_mem[s_axis_tdata];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // Output queue: the read stage always finds room, as input is held back in time.
  assign q_pop         = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (q_count != 2'd0);
  assign m_axis_tdata  = queue[q_rd_ptr];

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      queue[q_wr_ptr] <= table_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      if (rd_valid) q_wr_ptr <= ptr_inc(q_wr_ptr);
      if (q_pop) q_rd_ptr <= ptr_inc(q_rd_ptr);
      q_count <= q_count + 2'(rd_valid) - 2'(q_pop);
    end
  end

  // A table write must never coincide with an item being looked up.
  a_no_read_during_write: assert property (@(posedge clk) disable iff (rst)
    calc_st.wr_valid |-> !rd_en)
    else $error("table written while an item is read");

  // The read stage must always find room in the output queue.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && !q_pop) |-> (q_count != 2'(QUEUE_DEPTH)))
    else $error("output queue overflow");

  // A configuration write starts a rebuild, so no item is taken right after it.
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !s_axis_tready)
    else $error("input accepted during table rebuild");

endmodule
